// File: hw/rtl/dlpt_pkg.sv
// Shared types and constants for the delayed looping phase timer.
// No dependencies; imported by every module of the block but dlpt_div.
`default_nettype none

package dlpt_pkg;

    localparam int TIME_BITS_DEF = 24;
    localparam int LOOP_BITS_DEF = 8;

    // loop_count takes only the low byte of the write data
    localparam int CFG_LOOP_FIELD = 8;
    localparam int CFG_IDX_BITS   = 2;
    localparam int LOOP_RESET     = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_START_DELAY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOOP_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_START   = 2'd1,
        PH_PLAYING = 2'd2,
        PH_END     = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_DELAY  = 4'd2,
        OP_SKIP   = 4'd3,
        OP_DIVEND = 4'd4,
        OP_MUL    = 4'd5,
        OP_SUB    = 4'd6,
        OP_ABSORB = 4'd7,
        OP_PLACE  = 4'd8,
        OP_INF    = 4'd9,
        OP_FINAL  = 4'd10,
        OP_EMIT   = 4'd11
    } dp_op_t;

    typedef struct packed {
        logic delay_big;   // remaining delay exceeds the chunk
        logic ended;       // phase is end
        logic infinite;    // loop_count is zero
        logic div_go;      // skip step needs the divider
        logic div_done;
        logic q_gt_avail;  // more whole periods than loops left
        logic loops_done;  // loop counter reached loop_count
        logic sum_gt_p;    // position plus chunk overruns the period
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/dlpt_div.sv
// Restoring divider, one quotient bit per cycle, for the timer datapath.
// Depends on nothing but its width parameter.
`default_nettype none

module dlpt_div #(
    parameter int W = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     qd_reg, qd_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             ge;

    always_comb
    begin
        shifted  = {acc_reg, qd_reg[W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        ge       = !diff[W];
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        qd_next  = qd_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = CNT_W'(W);
            acc_next = '0;
            qd_next  = dividend;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            acc_next = ge ? diff[W-1:0] : shifted[W-1:0];
            qd_next  = {qd_reg[W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        qd_reg  <= qd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = (cnt_reg == '0);
    assign quotient  = qd_reg;
    assign remainder = acc_reg;

endmodule

`default_nettype wire

// File: hw/rtl/dlpt_datapath.sv
// Timer datapath: configuration, timer state, working chunk, multiplier,
// divider and output registers. Depends on dlpt_pkg and dlpt_div.
`default_nettype none

module dlpt_datapath
    import dlpt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int LOOP_BITS = LOOP_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [TIME_BITS-1:0]    cfg_data,
    input  wire logic [TIME_BITS-1:0]    elapsed_ticks,
    input  dp_op_t                       op,
    output dp_status_t                   status,
    output logic [TIME_BITS-1:0]         leftover_ticks,
    output logic [1:0]                   phase,
    output logic [TIME_BITS-1:0]         phase_time,
    output logic [LOOP_BITS-1:0]         loops_done
);

    localparam int CW = (TIME_BITS > LOOP_BITS) ? TIME_BITS : LOOP_BITS;
    localparam int PW = TIME_BITS + LOOP_BITS;

    logic [TIME_BITS-1:0] start_delay_reg, start_delay_next;
    logic [TIME_BITS-1:0] period_reg, period_next;
    logic [LOOP_BITS-1:0] loop_count_reg, loop_count_next;
    logic [TIME_BITS-1:0] delay_left_reg, delay_left_next;
    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] position_reg, position_next;
    logic [LOOP_BITS-1:0] counter_reg, counter_next;

    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [TIME_BITS-1:0] prod_reg, prod_next;
    logic [TIME_BITS-1:0] out_left_reg, out_left_next;
    phase_t               out_phase_reg, out_phase_next;
    logic [TIME_BITS-1:0] out_pos_reg, out_pos_next;
    logic [LOOP_BITS-1:0] out_loops_reg, out_loops_next;

    logic [TIME_BITS-1:0] p_eff;
    logic [LOOP_BITS-1:0] avail;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS:0]   sum_wrap;
    logic [LOOP_BITS:0]   counter_inc;
    logic [PW-1:0]        prod_full;
    logic                 infinite;
    logic                 loops_done_now;
    logic                 div_start;
    logic                 div_done;
    logic [TIME_BITS-1:0] quotient;
    logic [TIME_BITS-1:0] remainder;

    assign p_eff          = (period_reg == '0) ? TIME_BITS'(1) : period_reg;
    assign infinite       = (loop_count_reg == '0);
    assign loops_done_now = (counter_reg >= loop_count_reg);
    assign avail          = loop_count_reg - counter_reg;
    assign sum            = {1'b0, position_reg} + {1'b0, rem_reg};
    assign sum_wrap       = sum - {1'b0, p_eff};
    assign counter_inc    = {1'b0, counter_reg} + 1'b1;
    assign prod_full      = PW'(avail) * PW'(period_reg);

    assign div_start = (op == OP_SKIP) && status.div_go;

    always_comb
    begin
        status.delay_big  = (delay_left_reg > rem_reg);
        status.ended      = (phase_reg == PH_END);
        status.infinite   = infinite;
        status.div_go     = (rem_reg != '0)
                            && (infinite || (!loops_done_now && period_reg != '0));
        status.div_done   = div_done;
        status.q_gt_avail = (CW'(quotient) > CW'(avail));
        status.loops_done = loops_done_now;
        status.sum_gt_p   = (sum > {1'b0, period_reg});
    end

    dlpt_div #(
        .W (TIME_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rem_reg - 1'b1),
        .divisor   (p_eff),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb
    begin
        start_delay_next = start_delay_reg;
        period_next      = period_reg;
        loop_count_next  = loop_count_reg;
        delay_left_next  = delay_left_reg;
        phase_next       = phase_reg;
        position_next    = position_reg;
        counter_next     = counter_reg;
        rem_next         = rem_reg;
        prod_next        = prod_reg;
        out_left_next    = out_left_reg;
        out_phase_next   = out_phase_reg;
        out_pos_next     = out_pos_reg;
        out_loops_next   = out_loops_reg;

        case (op)
            OP_LOAD:
            begin
                rem_next = elapsed_ticks;
            end
            OP_DELAY:
            begin
                if (status.delay_big)
                begin
                    delay_left_next = delay_left_reg - rem_reg;
                end
                else
                begin
                    delay_left_next = '0;
                    if (status.ended)
                    begin
                        rem_next = '0;
                    end
                    else
                    begin
                        rem_next   = rem_reg - delay_left_reg;
                        phase_next = (phase_reg == PH_WAIT) ? PH_START : PH_PLAYING;
                    end
                end
            end
            OP_SKIP:
            begin
                // zero period: every loop left is skipped, chunk untouched
                if (!infinite && !loops_done_now && rem_reg != '0 && period_reg == '0)
                begin
                    counter_next = loop_count_reg;
                end
            end
            OP_DIVEND:
            begin
                if (infinite || !status.q_gt_avail)
                begin
                    rem_next = remainder + 1'b1;
                end
                if (!infinite && !status.q_gt_avail)
                begin
                    counter_next = counter_reg + LOOP_BITS'(quotient);
                end
            end
            OP_MUL:
            begin
                prod_next = prod_full[TIME_BITS-1:0];
            end
            OP_SUB:
            begin
                rem_next     = rem_reg - prod_reg;
                counter_next = loop_count_reg;
            end
            OP_ABSORB:
            begin
                if (status.sum_gt_p)
                begin
                    rem_next      = TIME_BITS'(sum - {1'b0, period_reg});
                    counter_next  = counter_inc[LOOP_BITS-1:0];
                    position_next = '0;
                end
                else
                begin
                    position_next = sum[TIME_BITS-1:0];
                    rem_next      = '0;
                end
            end
            OP_PLACE:
            begin
                position_next = rem_reg;
                rem_next      = '0;
            end
            OP_INF:
            begin
                position_next = (sum >= {1'b0, p_eff}) ? sum_wrap[TIME_BITS-1:0]
                                                       : sum[TIME_BITS-1:0];
                rem_next      = '0;
            end
            OP_FINAL:
            begin
                if (loops_done_now)
                begin
                    position_next = period_reg;
                    phase_next    = PH_END;
                end
                else if (position_reg == period_reg
                         && counter_inc < {1'b0, loop_count_reg})
                begin
                    position_next = '0;
                    counter_next  = counter_inc[LOOP_BITS-1:0];
                end
            end
            OP_EMIT:
            begin
                out_left_next  = rem_reg;
                out_phase_next = phase_reg;
                out_pos_next   = position_reg;
                out_loops_next = counter_reg;
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                REG_START_DELAY:
                begin
                    start_delay_next = cfg_data;
                    delay_left_next  = cfg_data;
                end
                REG_PERIOD:
                begin
                    period_next = cfg_data;
                end
                REG_LOOP_COUNT:
                begin
                    loop_count_next = LOOP_BITS'(cfg_data[CFG_LOOP_FIELD-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg <= '0;
            period_reg      <= '0;
            loop_count_reg  <= LOOP_BITS'(LOOP_RESET);
            delay_left_reg  <= '0;
            phase_reg       <= PH_WAIT;
            position_reg    <= '0;
            counter_reg     <= '0;
        end
        else
        begin
            start_delay_reg <= start_delay_next;
            period_reg      <= period_next;
            loop_count_reg  <= loop_count_next;
            delay_left_reg  <= delay_left_next;
            phase_reg       <= phase_next;
            position_reg    <= position_next;
            counter_reg     <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        prod_reg      <= prod_next;
        out_left_reg  <= out_left_next;
        out_phase_reg <= out_phase_next;
        out_pos_reg   <= out_pos_next;
        out_loops_reg <= out_loops_next;
    end

    assign leftover_ticks = out_left_reg;
    assign phase          = out_phase_reg;
    assign phase_time     = out_pos_reg;
    assign loops_done     = out_loops_reg;

endmodule

`default_nettype wire

// File: hw/rtl/dlpt_ctrl.sv
// Timer controller: sequences the datapath for one item and runs both
// handshakes. Depends on dlpt_pkg.
`default_nettype none

module dlpt_ctrl
    import dlpt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  wire logic  out_stall,
    input  dp_status_t status,
    output dp_op_t     op
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DELAY  = 13'b0000000000010,
        S_SKIP   = 13'b0000000000100,
        S_DIV    = 13'b0000000001000,
        S_DIVEND = 13'b0000000010000,
        S_MUL    = 13'b0000000100000,
        S_SUB    = 13'b0000001000000,
        S_CHECK  = 13'b0000010000000,
        S_ABSORB = 13'b0000100000000,
        S_PLACE  = 13'b0001000000000,
        S_INF    = 13'b0010000000000,
        S_FINAL  = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && out_stall;
        op             = OP_NONE;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DELAY;
                end
            end
            S_DELAY:
            begin
                op        = OP_DELAY;
                pass_next = 1'b0;
                state_next = (status.delay_big || status.ended) ? S_EMIT : S_SKIP;
            end
            S_SKIP:
            begin
                op         = OP_SKIP;
                state_next = status.div_go ? S_DIV : S_CHECK;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_DIVEND;
                end
            end
            S_DIVEND:
            begin
                op         = OP_DIVEND;
                state_next = (!status.infinite && status.q_gt_avail) ? S_MUL : S_CHECK;
            end
            S_MUL:
            begin
                op         = OP_MUL;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                op         = OP_SUB;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.infinite)
                begin
                    state_next = S_INF;
                end
                else if (status.loops_done)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = pass_reg ? S_PLACE : S_ABSORB;
                end
            end
            S_ABSORB:
            begin
                op = OP_ABSORB;
                // overrun: the excess goes through a second skip pass
                if (status.sum_gt_p)
                begin
                    pass_next  = 1'b1;
                    state_next = S_SKIP;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_PLACE:
            begin
                op         = OP_PLACE;
                state_next = S_FINAL;
            end
            S_INF:
            begin
                op         = OP_INF;
                state_next = S_EMIT;
            end
            S_FINAL:
            begin
                op         = OP_FINAL;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    op             = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/delayed_looping_phase_timer_unit.sv
// Top level of the delayed looping phase timer.
// Depends on dlpt_pkg, dlpt_ctrl, dlpt_datapath (and dlpt_div below it).
//
// Usage:
//   Input channel (in_valid / in_stall / elapsed_ticks) carries one item of
//   elapsed time; output channel (out_valid / out_stall / fields) returns one
//   result item per input item, in order. Registers are written through
//   cfg_we / cfg_index / cfg_data while no item is in flight; a write of the
//   start delay also reloads the remaining delay.
//   The controller loads the chunk, pays off the remaining delay and goes
//   straight to the result when the delay absorbs the chunk or the timer has
//   ended; otherwise the skip step may use the divider, and in finite mode,
//   when the position overruns the period, a second skip pass may use it
//   again. The divider is a restoring one, one quotient bit per cycle.
//   One item is processed at a time; in_stall is low only when the
//   controller is idle, so no new item is taken before the last is emitted.
//   The result sits in an output register: a stalled receiver does not block
//   acceptance of the next item, only the hand-off of its result.
//   Reset clears the registers to start delay 0, period 0, loop count 1 and
//   the timer to the wait phase; the block is ready once reset is released.
`default_nettype none

module delayed_looping_phase_timer_unit
    import dlpt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int LOOP_BITS = LOOP_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [TIME_BITS-1:0]    cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [TIME_BITS-1:0]    elapsed_ticks,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [TIME_BITS-1:0]         leftover_ticks,
    output logic [1:0]                   phase,
    output logic [TIME_BITS-1:0]         phase_time,
    output logic [LOOP_BITS-1:0]         loops_done
);

    dp_op_t     op;
    dp_status_t status;

    dlpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .op        (op)
    );

    dlpt_datapath #(
        .TIME_BITS (TIME_BITS),
        .LOOP_BITS (LOOP_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .elapsed_ticks  (elapsed_ticks),
        .op             (op),
        .status         (status),
        .leftover_ticks (leftover_ticks),
        .phase          (phase),
        .phase_time     (phase_time),
        .loops_done     (loops_done)
    );

endmodule

`default_nettype wire

// File: hw/rtl/dlpt_checker.sv
// Port-level checks for the delayed looping phase timer, bound to the top.
// Depends on dlpt_pkg and delayed_looping_phase_timer_unit.
`default_nettype none

module dlpt_checker
    import dlpt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int LOOP_BITS = LOOP_BITS_DEF
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [TIME_BITS-1:0] leftover_ticks,
    input wire logic [1:0]           phase,
    input wire logic [TIME_BITS-1:0] phase_time,
    input wire logic [LOOP_BITS-1:0] loops_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(leftover_ticks)
            && $stable(phase) && $stable(phase_time) && $stable(loops_done))
        else $error("stalled result changed");

    // one item at a time: an accepted item closes the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after an accepted item");

    // a new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work");

    // still waiting on the start delay: nothing has moved yet
    a_wait_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == PH_WAIT |-> phase_time == '0 && loops_done == '0)
        else $error("wait phase with nonzero position or loops");

endmodule

bind delayed_looping_phase_timer_unit dlpt_checker #(
    .TIME_BITS (TIME_BITS),
    .LOOP_BITS (LOOP_BITS)
) u_dlpt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .leftover_ticks (leftover_ticks),
    .phase          (phase),
    .phase_time     (phase_time),
    .loops_done     (loops_done)
);

`default_nettype wire

// File: tb/sv/tb_delayed_looping_phase_timer_unit.sv
// Self-checking testbench for delayed_looping_phase_timer_unit.
// Needs dlpt_pkg and timer RTL; a built-in model predicts all but typed results.
// Directed table first, then random register phases, then rows that end the timer.
`timescale 1ns / 1ps
`default_nettype none

module tb_delayed_looping_phase_timer_unit;
    import dlpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = TIME_BITS_DEF;
    localparam int LW = LOOP_BITS_DEF;
    localparam logic [TW-1:0] TIME_MAX = '1;
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 100;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic [TW-1:0] delay_left;
        phase_t        ph;
        logic [TW-1:0] position;
        logic [LW-1:0] loop_counter;
    } timer_state_t;

    typedef struct {
        logic [TW-1:0] leftover;
        phase_t        ph;
        logic [TW-1:0] ptime;
        logic [LW-1:0] loops;
    } timer_out_t;

    typedef enum logic [1:0] {
        ROW_REG,
        ROW_ITEM,
        ROW_TYPED,
        ROW_RANDOM
    } row_kind_e;

    typedef struct {
        row_kind_e              kind;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [TW-1:0]          value;
        timer_out_t             want;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [TW-1:0]           cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [TW-1:0]           elapsed_ticks = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [TW-1:0]           leftover_ticks;
    logic [1:0]              phase;
    logic [TW-1:0]           phase_time;
    logic [LW-1:0]           loops_done;

    timer_state_t timer_now;
    logic [TW-1:0] cfg_period;
    logic [LW-1:0] cfg_loops;
    timer_out_t timer_outs_due[$];
    timer_out_t head_out;
    stim_row_t stimulus_rows[$];
    int err_count = 0;
    int cycle_count = 0;
    bit steady = 1'b0;
    bit hold_request = 1'b0;

    delayed_looping_phase_timer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .elapsed_ticks  (elapsed_ticks),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .leftover_ticks (leftover_ticks),
        .phase          (phase),
        .phase_time     (phase_time),
        .loops_done     (loops_done)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_delayed_looping_phase_timer_unit: errors");
            $finish;
        end
    end

    // Advance the timer by one chunk of elapsed ticks and form its result.
    function automatic void advance_timer(inout timer_state_t s, input logic [TW-1:0] ticks,
                                          output timer_out_t r);
        logic [63:0] rem;
        logic [63:0] p;
        logic [63:0] pos;
        logic [63:0] cnt;
        logic [63:0] lim;
        rem = ticks;
        pos = s.position;
        cnt = s.loop_counter;
        lim = cfg_loops;
        r.leftover = '0;
        if (s.delay_left > rem)
        begin
            s.delay_left = s.delay_left - ticks;
            r.leftover = ticks;
        end
        else
        begin
            rem = rem - s.delay_left;
            s.delay_left = '0;
            if (s.ph != PH_END)
            begin
                s.ph = (s.ph == PH_WAIT) ? PH_START : PH_PLAYING;
                if (lim == 0)
                begin
                    p = cfg_period;
                    if (p == 0)
                        p = 1;
                    if (rem > p)
                        rem = ((rem - 1) % p) + 1;
                    pos = pos + rem;
                    if (pos >= p)
                        pos = pos - p;
                end
                else
                begin
                    p = cfg_period;
                    while (cnt < lim)
                    begin
                        // a chunk longer than the period skips it whole
                        if (p < rem)
                        begin
                            rem = rem - p;
                            cnt++;
                        end
                        else if (pos + rem > p)
                        begin
                            rem = pos + rem - p;
                            cnt++;
                            pos = 0;
                        end
                        else
                        begin
                            pos = pos + rem;
                            rem = 0;
                            break;
                        end
                    end
                    if (cnt >= lim)
                    begin
                        pos = p;
                        s.ph = PH_END;
                    end
                    else if (pos == p && cnt + 1 < lim)
                    begin
                        pos = 0;
                        cnt++;
                    end
                    r.leftover = rem[TW-1:0];
                end
            end
        end
        s.position = pos[TW-1:0];
        s.loop_counter = cnt[LW-1:0];
        r.ph = s.ph;
        r.ptime = s.position;
        r.loops = s.loop_counter;
    endfunction

    function automatic logic [TW-1:0] draw_ticks();
        int unsigned pick;
        int unsigned top;
        pick = $urandom_range(0, 10);
        case (pick)
            0: return $urandom;
            1: return '0;
            2: return TIME_MAX;
            3: return $urandom_range(0, 7);
            4, 5, 6: return $urandom_range(0, cfg_period);
            7, 8:
            begin
                top = 3 * cfg_period + 3;
                return $urandom_range(0, top);
            end
            9: return cfg_period;
            default: return $urandom_range(0, timer_now.delay_left);
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        err_count++;
        if (err_count <= 100)
            $display("%0t ns mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    task automatic add_row(input row_kind_e kind, input logic [TW-1:0] value);
        stim_row_t row;
        row.kind = kind;
        row.idx = '0;
        row.value = value;
        row.want = '{'0, PH_WAIT, '0, '0};
        stimulus_rows.push_back(row);
    endtask

    task automatic add_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [TW-1:0] value);
        stim_row_t row;
        row.kind = ROW_REG;
        row.idx = idx;
        row.value = value;
        row.want = '{'0, PH_WAIT, '0, '0};
        stimulus_rows.push_back(row);
    endtask

    task automatic add_typed(input logic [TW-1:0] ticks, input logic [TW-1:0] left,
                             input phase_t ph, input logic [TW-1:0] ptime,
                             input logic [LW-1:0] loops);
        stim_row_t row;
        row.kind = ROW_TYPED;
        row.idx = '0;
        row.value = ticks;
        row.want = '{left, ph, ptime, loops};
        stimulus_rows.push_back(row);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (timer_outs_due.size() != 0)
            @(posedge clk);
    endtask

    // Leave cfg_we high; the next item lowers it.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [TW-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_START_DELAY: timer_now.delay_left = value;
            REG_PERIOD: cfg_period = value;
            REG_LOOP_COUNT: cfg_loops = value[LW-1:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [TW-1:0] ticks, input bit use_want,
                             input timer_out_t want);
        int gap;
        timer_out_t r;
        gap = steady ? 0 : $urandom_range(0, 7);
        cfg_we <= 1'b0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        elapsed_ticks <= ticks;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_timer(timer_now, ticks, r);
        timer_outs_due.push_back(use_want ? want : r);
    endtask

    task automatic run_random();
        int n;
        int k;
        int phase_no;
        int sent;
        int pick;
        bit endless;
        logic [TW-1:0] period_val;
        logic [TW-1:0] ticks;
        logic [LW-1:0] loops_val;
        logic [TW-LW-1:0] junk;
        timer_state_t trial;
        timer_out_t r;
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            endless = (timer_now.loop_counter > 230) || ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                period_val = '0;
            else if (pick == 1)
                period_val = TIME_MAX;
            else if (pick < 7)
                period_val = $urandom_range(1, 64);
            else
                period_val = $urandom;
            // zero period in finite mode would use up every loop at once
            if (!endless && period_val == 0)
                period_val = 1;
            if (endless)
                loops_val = '0;
            else if ($urandom_range(0, 2) == 0)
                loops_val = '1;
            else
                loops_val = $urandom_range(int'(timer_now.loop_counter) + 10, 255);
            junk = $urandom;
            write_reg(REG_PERIOD, period_val);
            write_reg(REG_LOOP_COUNT, {junk, loops_val});
            pick = $urandom_range(0, 5);
            if (pick == 0)
                write_reg(REG_START_DELAY, '0);
            else if (pick == 1)
                write_reg(REG_START_DELAY, $urandom_range(1, 100));
            else if (pick == 2)
                write_reg(REG_START_DELAY, $urandom);
            steady = ($urandom_range(0, 3) == 0);
            n = $urandom_range(10, 40);
            if (phase_no == 0)
            begin
                hold_request = 1'b1;
                n = 40;
            end
            for (k = 0; k < n; k++)
            begin
                ticks = draw_ticks();
                trial = timer_now;
                advance_timer(trial, ticks, r);
                // keep the timer running; the closing rows end it
                if (trial.ph == PH_END)
                    break;
                send_item(ticks, 1'b0, r);
                sent++;
            end
            phase_no++;
        end
        steady = 1'b0;
    endtask

    // Result side: random stalls per item, one long hold-off on request.
    initial
    begin : results_sink
        int wait_cycles;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                wait_cycles = steady ? 0 : $urandom_range(0, 7);
                if (wait_cycles != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (timer_outs_due.size() == 0)
                flag_mismatch("item with none due", '0, '0);
            else
            begin
                head_out = timer_outs_due.pop_front();
                if (leftover_ticks !== head_out.leftover)
                    flag_mismatch("leftover_ticks", leftover_ticks, head_out.leftover);
                if (phase !== head_out.ph)
                    flag_mismatch("phase", phase, head_out.ph);
                if (phase_time !== head_out.ptime)
                    flag_mismatch("phase_time", phase_time, head_out.ptime);
                if (loops_done !== head_out.loops)
                    flag_mismatch("loops_done", loops_done, head_out.loops);
            end
        end
    end

    initial
    begin
        timer_now.delay_left = '0;
        timer_now.ph = PH_WAIT;
        timer_now.position = '0;
        timer_now.loop_counter = '0;
        cfg_period = '0;
        cfg_loops = LOOP_RESET;

        // reset state: finite, one loop, zero period
        add_typed('0, '0, PH_START, '0, '0);
        // infinite mode; upper data bits are ignored
        add_reg(REG_LOOP_COUNT, 24'hABCD00);
        add_typed(TIME_MAX, '0, PH_PLAYING, '0, '0);
        add_reg(REG_PERIOD, TIME_MAX);
        add_typed(TIME_MAX, '0, PH_PLAYING, '0, '0);
        add_typed(24'd1, '0, PH_PLAYING, 24'd1, '0);
        add_typed(TIME_MAX - 1, '0, PH_PLAYING, '0, '0);
        // delay larger than the chunk, then paid off exactly
        add_reg(REG_START_DELAY, TIME_MAX);
        add_typed(TIME_MAX - 1, TIME_MAX - 1, PH_PLAYING, '0, '0);
        add_typed('0, '0, PH_PLAYING, '0, '0);
        add_typed(24'd1, '0, PH_PLAYING, '0, '0);
        add_row(ROW_ITEM, 24'd5);
        // shrink the period below the position
        add_reg(REG_PERIOD, 24'd3);
        add_row(ROW_ITEM, 24'd0);
        add_row(ROW_ITEM, 24'd7);
        add_reg(REG_START_DELAY, '0);
        add_reg(REG_PERIOD, 24'd10);
        add_reg(REG_LOOP_COUNT, 24'd255);
        add_row(ROW_ITEM, 24'd4);
        // lands exactly on the period
        add_row(ROW_ITEM, 24'd6);
        add_row(ROW_ITEM, 24'd25);
        add_row(ROW_ITEM, 24'd8);
        add_reg(REG_PERIOD, 24'd2);
        add_row(ROW_ITEM, 24'd0);
        add_row(ROW_RANDOM, '0);
        // zero period in finite mode runs every loop and ends the timer
        add_reg(REG_PERIOD, '0);
        add_reg(REG_LOOP_COUNT, 24'd255);
        add_reg(REG_START_DELAY, 24'd2);
        add_typed(24'd5, 24'd3, PH_END, '0, 8'd255);
        add_typed('0, '0, PH_END, '0, 8'd255);
        add_typed(TIME_MAX, '0, PH_END, '0, 8'd255);
        add_reg(REG_START_DELAY, 24'd10);
        add_typed(24'd4, 24'd4, PH_END, '0, 8'd255);
        add_typed(24'd6, '0, PH_END, '0, 8'd255);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stimulus_rows[i])
        begin
            case (stimulus_rows[i].kind)
                ROW_REG:
                begin
                    drain_results();
                    write_reg(stimulus_rows[i].idx, stimulus_rows[i].value);
                end
                ROW_ITEM: send_item(stimulus_rows[i].value, 1'b0, stimulus_rows[i].want);
                ROW_TYPED: send_item(stimulus_rows[i].value, 1'b1, stimulus_rows[i].want);
                default: run_random();
            endcase
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_delayed_looping_phase_timer_unit: clean");
        else
            $display("tb_delayed_looping_phase_timer_unit: errors");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/dlpt_pkg.sv
hw/rtl/dlpt_div.sv
hw/rtl/dlpt_datapath.sv
hw/rtl/dlpt_ctrl.sv
hw/rtl/delayed_looping_phase_timer_unit.sv
hw/rtl/dlpt_checker.sv
tb/sv/tb_delayed_looping_phase_timer_unit.sv
